// ===== rtl/core/cts_pkg.sv =====
`timescale 1ns / 1ps
package cts_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int KW_COUNT        = 6;

	typedef enum logic [2:0] {
		KIND_KEYWORD    = 3'd0,
		KIND_IDENTIFIER = 3'd1,
		KIND_NUMBER     = 3'd2,
		KIND_OPERATOR   = 3'd3,
		KIND_DELIMITER  = 3'd4,
		KIND_UNKNOWN    = 3'd5
	} tok_kind_t;

	localparam logic [2:0] KW_INT    = 3'd0;
	localparam logic [2:0] KW_NONE   = 3'd6;

	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_EQUAL  = 8'h3d;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;

	// int, float, if, else, while, return; first byte in the low bits
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'h0000_0074_6e69,
		48'h0074_616f_6c66,
		48'h0000_0000_6669,
		48'h0000_6573_6c65,
		48'h0065_6c69_6877,
		48'h6e72_7574_6572
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6};

	typedef struct packed {
		logic       has_flush;
		logic       has_char;
		tok_kind_t  flush_kind;
		logic [2:0] flush_kw;
		logic [7:0] flush_char;
		tok_kind_t  char_kind;
		logic [7:0] char_byte;
	} cts_entry_t;

	localparam int ENTRY_BITS = $bits(cts_entry_t);

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [2:0] kw_lookup(input logic [47:0] six, input logic [2:0] len);
		logic [2:0] idx;
		idx = KW_NONE;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (len == KW_LEN[i] && six == KW_TEXT[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/core/cts_stream_if.sv =====
`timescale 1ns / 1ps
interface cts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface cts_tok_if #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [2:0]             kind;
	logic [2:0]             keyword_index;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [LENGTH_BITS-1:0] length;
	logic [7:0]             single_char;
	logic                   last;

	modport source (output valid, output kind, output keyword_index, output start_offset,
		output length, output single_char, output last, input ready);
	modport sink (input valid, input kind, input keyword_index, input start_offset,
		input length, input single_char, input last, output ready);
endinterface

// ===== rtl/core/cts_front.sv =====
`timescale 1ns / 1ps
module cts_front import cts_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cts_byte_if.sink               chars,
	input  logic                   q_full,
	output logic                   q_push,
	output cts_entry_t             q_entry,
	output logic [OFFSET_BITS-1:0] q_flush_start,
	output logic [LENGTH_BITS-1:0] q_flush_len,
	output logic [OFFSET_BITS-1:0] q_char_start
);

	typedef enum logic [2:0] {
		RUN_IDLE  = 3'b001,
		RUN_IDENT = 3'b010,
		RUN_NUM   = 3'b100
	} run_mode_t;

	run_mode_t              run_mode_q;
	logic [OFFSET_BITS-1:0] run_start_q;
	logic [LENGTH_BITS-1:0] run_len_q;
	logic [47:0]            run_six_q;
	logic [OFFSET_BITS-1:0] pos_q;

	logic       xfer, eoi, letter, digit, space, extend, flush;
	logic [2:0] kw;
	tok_kind_t  ckind;
	cts_entry_t entry;

	assign chars.ready = !q_full;
	assign xfer   = chars.valid && chars.ready;
	assign eoi    = chars.end_of_input;
	assign letter = is_letter(chars.ch);
	assign digit  = is_digit(chars.ch);
	assign space  = is_space(chars.ch);
	assign extend = !eoi && ((run_mode_q == RUN_IDENT && (letter || digit)) ||
		(run_mode_q == RUN_NUM && digit));
	assign flush  = run_mode_q != RUN_IDLE && !extend;
	assign kw     = (run_len_q <= LENGTH_BITS'(6)) ? kw_lookup(run_six_q, run_len_q[2:0]) : KW_NONE;

	always_comb begin
		unique case (chars.ch)
			CH_PLUS, CH_MINUS, CH_STAR, CH_EQUAL:   ckind = KIND_OPERATOR;
			CH_SEMI, CH_COMMA, CH_LPAREN, CH_RPAREN: ckind = KIND_DELIMITER;
			default:                                 ckind = KIND_UNKNOWN;
		endcase
	end

	always_comb begin
		entry.has_flush  = flush;
		entry.has_char   = !eoi && !extend && !space && !letter && !digit;
		entry.flush_char = run_six_q[7:0];
		entry.char_kind  = ckind;
		entry.char_byte  = chars.ch;
		if (run_mode_q == RUN_NUM) begin
			entry.flush_kind = KIND_NUMBER;
			entry.flush_kw   = KW_INT;
		end else if (kw != KW_NONE) begin
			entry.flush_kind = KIND_KEYWORD;
			entry.flush_kw   = kw;
		end else begin
			entry.flush_kind = KIND_IDENTIFIER;
			entry.flush_kw   = KW_INT;
		end
	end

	assign q_push        = xfer && (entry.has_flush || entry.has_char);
	assign q_entry       = entry;
	assign q_flush_start = run_start_q;
	assign q_flush_len   = run_len_q;
	assign q_char_start  = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q  <= RUN_IDLE;
			run_start_q <= '0;
			run_len_q   <= '0;
			run_six_q   <= '0;
			pos_q       <= '0;
		end else if (xfer) begin
			if (eoi) begin
				run_mode_q <= RUN_IDLE;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (extend) begin
					if (run_len_q < LENGTH_BITS'(6)) begin
						run_six_q[8*run_len_q[2:0] +: 8] <= chars.ch;
					end
					if (run_len_q != '1) begin
						run_len_q <= run_len_q + 1'b1;
					end
				end else if (letter || digit) begin
					run_mode_q  <= letter ? RUN_IDENT : RUN_NUM;
					run_start_q <= pos_q;
					run_len_q   <= LENGTH_BITS'(1);
					run_six_q   <= {40'd0, chars.ch};
				end else begin
					run_mode_q <= RUN_IDLE;
				end
			end
		end
	end

endmodule

// ===== rtl/core/cts_queue.sv =====
`timescale 1ns / 1ps
module cts_queue #(
	parameter int DATA_BITS = 8,
	parameter int DEPTH     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] rdata,
	output logic                 full,
	output logic                 nonempty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_q, rd_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 do_push, do_pop;

	assign full     = cnt_q == CNT_BITS'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/cts_back.sv =====
`timescale 1ns / 1ps
module cts_back import cts_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_nonempty,
	input  cts_entry_t             q_entry,
	input  logic [OFFSET_BITS-1:0] q_flush_start,
	input  logic [LENGTH_BITS-1:0] q_flush_len,
	input  logic [OFFSET_BITS-1:0] q_char_start,
	output logic                   q_pop,
	cts_tok_if.source              tokens
);

	logic                   valid_q;
	logic                   second_q;
	logic [2:0]             kind_q;
	logic [2:0]             kw_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [7:0]             char_q;
	logic                   last_q;

	logic load, take_flush;

	assign load       = !valid_q || tokens.ready;
	assign take_flush = q_entry.has_flush && !second_q;
	assign q_pop      = load && q_nonempty && !(take_flush && q_entry.has_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_nonempty;
			if (q_nonempty) begin
				second_q <= take_flush && q_entry.has_char;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_nonempty) begin
			if (take_flush) begin
				kind_q  <= q_entry.flush_kind;
				kw_q    <= q_entry.flush_kw;
				start_q <= q_flush_start;
				len_q   <= q_flush_len;
				char_q  <= q_entry.flush_char;
				last_q  <= !q_entry.has_char;
			end else begin
				kind_q  <= q_entry.char_kind;
				kw_q    <= KW_INT;
				start_q <= q_char_start;
				len_q   <= LENGTH_BITS'(1);
				char_q  <= q_entry.char_byte;
				last_q  <= 1'b1;
			end
		end
	end

	assign tokens.valid         = valid_q;
	assign tokens.kind          = kind_q;
	assign tokens.keyword_index = kw_q;
	assign tokens.start_offset  = start_q;
	assign tokens.length        = len_q;
	assign tokens.single_char   = char_q;
	assign tokens.last          = last_q;

endmodule

// ===== rtl/core/c_subset_token_scanner_core.sv =====
// Order: the first token of a byte is held in the queue, then in the back end's output register;
//   a second token of the same byte is loaded from the same queue entry after the first is taken.
// Throughput: one byte per cycle while the queue is not full; a byte that closes a run and is a token
//   itself yields two tokens on the token port, a 4-entry queue absorbs the difference.
// Rate is set by the single token output port of the back end.
// Reset: arst_n clears run state, byte position, queue and output valid at once.
`timescale 1ns / 1ps
module c_subset_token_scanner_core import cts_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cts_byte_if.sink  chars,
	cts_tok_if.source tokens
);

	localparam int Q_BITS = ENTRY_BITS + 2 * OFFSET_BITS + LENGTH_BITS;

	logic                   q_full, q_push, q_pop, q_nonempty;
	cts_entry_t             w_entry, r_entry;
	logic [OFFSET_BITS-1:0] w_fstart, w_cstart, r_fstart, r_cstart;
	logic [LENGTH_BITS-1:0] w_flen, r_flen;
	logic [Q_BITS-1:0]      q_wdata, q_rdata;

	cts_front #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (w_entry),
		.q_flush_start (w_fstart),
		.q_flush_len   (w_flen),
		.q_char_start  (w_cstart)
	);

	assign q_wdata = {w_entry, w_fstart, w_flen, w_cstart};

	cts_queue #(.DATA_BITS(Q_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	assign {r_entry, r_fstart, r_flen, r_cstart} = q_rdata;

	cts_back #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_nonempty    (q_nonempty),
		.q_entry       (r_entry),
		.q_flush_start (r_fstart),
		.q_flush_len   (r_flen),
		.q_char_start  (r_cstart),
		.q_pop         (q_pop),
		.tokens        (tokens)
	);

endmodule

// ===== rtl/core/cts_checker.sv =====
`timescale 1ns / 1ps
module cts_checker import cts_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   valid,
	input logic                   ready,
	input logic [2:0]             kind,
	input logic [2:0]             keyword_index,
	input logic [OFFSET_BITS-1:0] start_offset,
	input logic [LENGTH_BITS-1:0] length,
	input logic [7:0]             single_char,
	input logic                   last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(start_offset) && $stable(kind) && $stable(last))
		else $error("token changed while stalled");

	a_kw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind != KIND_KEYWORD |-> keyword_index == 3'd0)
		else $error("keyword index set on non-keyword");

	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_OPERATOR || kind == KIND_DELIMITER || kind == KIND_UNKNOWN)
		|-> length == LENGTH_BITS'(1) && last)
		else $error("single-byte token malformed");

	a_number: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_NUMBER |-> is_digit(single_char) && length != '0)
		else $error("number token does not start with digit");

endmodule

bind c_subset_token_scanner_core cts_checker #(
	.OFFSET_BITS (OFFSET_BITS),
	.LENGTH_BITS (LENGTH_BITS)
) u_cts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (tokens.valid),
	.ready         (tokens.ready),
	.kind          (tokens.kind),
	.keyword_index (tokens.keyword_index),
	.start_offset  (tokens.start_offset),
	.length        (tokens.length),
	.single_char   (tokens.single_char),
	.last          (tokens.last)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import cts_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int LONG_RUN = 40;
	localparam int PHASE_ITEMS = 330;
	localparam int PRESSURE_ITEMS = 40;
	localparam int PRINT_LIMIT = 40;
	localparam logic [15:0] LEN_FULL = 16'hffff;
	localparam logic [2:0] KW_INDEX_NONE = 3'd0;

	typedef enum int {
		KW_IDX_INT, KW_IDX_FLOAT, KW_IDX_IF, KW_IDX_ELSE, KW_IDX_WHILE, KW_IDX_RETURN,
		KW_IDX_COUNT
	} kw_idx_t;

	typedef enum logic [1:0] {RUN_IDLE, RUN_IDENT, RUN_NUMBER} run_t;

	typedef enum int {
		CLASS_LETTER, CLASS_DIGIT, CLASS_OP, CLASS_DELIM, CLASS_BLANK, CLASS_UNKNOWN
	} char_class_t;

	typedef struct {
		tok_kind_t   kind;
		logic [2:0]  kw;
		logic [31:0] start;
		logic [15:0] len;
		logic [7:0]  head_char;
		logic        last;
	} token_t;

	// spelling with the first character in the highest used byte
	function automatic logic [47:0] kw_spelling(int idx);
		case (idx)
			KW_IDX_INT:    return "int";
			KW_IDX_FLOAT:  return "float";
			KW_IDX_IF:     return "if";
			KW_IDX_ELSE:   return "else";
			KW_IDX_WHILE:  return "while";
			KW_IDX_RETURN: return "return";
			default:       return 48'd0;
		endcase
	endfunction

	function automatic int kw_size(int idx);
		case (idx)
			KW_IDX_INT:    return 3;
			KW_IDX_FLOAT:  return 5;
			KW_IDX_IF:     return 2;
			KW_IDX_ELSE:   return 4;
			KW_IDX_WHILE:  return 5;
			KW_IDX_RETURN: return 6;
			default:       return 0;
		endcase
	endfunction

	class token_scoreboard;
		run_t        run_mode;
		logic [31:0] run_start;
		logic [31:0] byte_pos;
		logic [15:0] run_length;
		logic [47:0] run_head;
		logic [7:0]  run_first;
		token_t      expected_tokens[$];
		int          mismatches;
		int          tokens_checked;
		int          items_taken;

		function new();
			run_mode = RUN_IDLE;
			run_start = '0;
			byte_pos = '0;
			run_length = '0;
			run_head = '0;
			run_first = '0;
			mismatches = 0;
			tokens_checked = 0;
			items_taken = 0;
		endfunction

		function void add_token(tok_kind_t kind, logic [2:0] kw, logic [31:0] start,
				logic [15:0] len, logic [7:0] c);
			token_t t;
			t.kind = kind;
			t.kw = kw;
			t.start = start;
			t.len = len;
			t.head_char = c;
			t.last = 1'b0;
			expected_tokens.push_back(t);
		endfunction

		function int keyword_match();
			for (int i = 0; i < KW_IDX_COUNT; i++) begin
				if (run_length == 16'(kw_size(i)) && run_head == kw_spelling(i)) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void close_run();
			int kw;
			kw = keyword_match();
			if (run_mode == RUN_IDENT) begin
				if (kw >= 0) begin
					add_token(KIND_KEYWORD, 3'(kw), run_start, run_length, run_first);
				end else begin
					add_token(KIND_IDENTIFIER, KW_INDEX_NONE, run_start, run_length, run_first);
				end
			end else if (run_mode == RUN_NUMBER) begin
				add_token(KIND_NUMBER, KW_INDEX_NONE, run_start, run_length, run_first);
			end
			run_mode = RUN_IDLE;
		endfunction

		function void open_run(run_t mode, logic [7:0] c);
			run_mode = mode;
			run_start = byte_pos;
			run_length = 16'd1;
			run_head = 48'(c);
			run_first = c;
		endfunction

		function void note_byte(logic [7:0] c, logic eoi);
			int   prior_count;
			logic alpha;
			logic num;
			logic blank;
			logic extend;
			prior_count = expected_tokens.size();
			items_taken++;
			alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
			num = c >= "0" && c <= "9";
			blank = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
			if (eoi) begin
				close_run();
			end else begin
				extend = (run_mode == RUN_IDENT && (alpha || num)) ||
					(run_mode == RUN_NUMBER && num);
				if (extend) begin
					if (run_length < 16'd6) begin
						run_head = {run_head[39:0], c};
					end
					if (run_length != LEN_FULL) begin
						run_length++;
					end
				end else begin
					close_run();
					if (alpha) begin
						open_run(RUN_IDENT, c);
					end else if (num) begin
						open_run(RUN_NUMBER, c);
					end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
							c == CH_EQUAL) begin
						add_token(KIND_OPERATOR, KW_INDEX_NONE, byte_pos, 16'd1, c);
					end else if (c == CH_SEMI || c == CH_COMMA || c == CH_LPAREN ||
							c == CH_RPAREN) begin
						add_token(KIND_DELIMITER, KW_INDEX_NONE, byte_pos, 16'd1, c);
					end else if (!blank) begin
						add_token(KIND_UNKNOWN, KW_INDEX_NONE, byte_pos, 16'd1, c);
					end
				end
				byte_pos++;
			end
			if (expected_tokens.size() > prior_count) begin
				expected_tokens[expected_tokens.size() - 1].last = 1'b1;
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_LIMIT) begin
				$display("MISMATCH token %0d: %s", tokens_checked, msg);
			end
		endtask

		task check_token(token_t got);
			token_t want;
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected token kind %0d offset %0d",
					got.kind, got.start));
				return;
			end
			want = expected_tokens.pop_front();
			if (got.kind != want.kind) begin
				report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
			end
			if (got.kw !== want.kw) begin
				report_mismatch($sformatf("keyword_index %0d, want %0d", got.kw, want.kw));
			end
			if (got.start !== want.start) begin
				report_mismatch($sformatf("start_offset %0d, want %0d", got.start, want.start));
			end
			if (got.len !== want.len) begin
				report_mismatch($sformatf("length %0d, want %0d", got.len, want.len));
			end
			if (got.head_char !== want.head_char) begin
				report_mismatch($sformatf("single_char %h, want %h", got.head_char,
					want.head_char));
			end
			if (got.last !== want.last) begin
				report_mismatch($sformatf("last %b, want %b", got.last, want.last));
			end
		endtask

		task check_drained();
			if (expected_tokens.size() != 0) begin
				report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	bit   hold_request;
	int   items_sent;
	token_scoreboard sb;

	cts_byte_if byte_bus ();
	cts_tok_if #(.OFFSET_BITS(32), .LENGTH_BITS(16)) token_bus ();

	c_subset_token_scanner_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(byte_bus),
		.tokens(token_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin : watch
		token_t got;
		if (arst_n) begin
			if (byte_bus.valid && byte_bus.ready) begin
				sb.note_byte(byte_bus.ch, byte_bus.end_of_input);
			end
			if (token_bus.valid && token_bus.ready) begin
				got.kind = tok_kind_t'(token_bus.kind);
				got.kw = token_bus.keyword_index;
				got.start = token_bus.start_offset;
				got.len = token_bus.length;
				got.head_char = token_bus.single_char;
				got.last = token_bus.last;
				sb.check_token(got);
			end
		end
	end

	initial begin : token_receiver
		token_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				token_bus.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					@(posedge clk);
				end
				hold_request = 1'b0;
			end else begin
				token_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic logic [7:0] pick_char(char_class_t cls);
		int r;
		r = $urandom_range(51);
		case (cls)
			CLASS_LETTER: return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
			CLASS_DIGIT:  return 8'("0" + $urandom_range(9));
			CLASS_OP: begin
				case (r % 4)
					0: return CH_PLUS;
					1: return CH_MINUS;
					2: return CH_STAR;
					default: return CH_EQUAL;
				endcase
			end
			CLASS_DELIM: begin
				case (r % 4)
					0: return CH_SEMI;
					1: return CH_COMMA;
					2: return CH_LPAREN;
					default: return CH_RPAREN;
				endcase
			end
			CLASS_BLANK: return (r % 6 == 5) ? CH_SPACE : CH_TAB + 8'(r % 5);
			default: begin
				case (r % 10)
					0: return 8'h00;
					1: return 8'h7f;
					2: return "#";
					3: return "{";
					4: return "_";
					5: return ".";
					default: return 8'($urandom_range(255, 128));
				endcase
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.ch <= c;
		byte_bus.end_of_input <= eoi;
		@(posedge clk);
		while (!byte_bus.ready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic send_text(input logic [8*24-1:0] txt, input int n);
		for (int j = n - 1; j >= 0; j--) begin
			send_byte(txt[8*j +: 8], 1'b0);
		end
	endtask

	// drop the first keep_off characters from the tail end of the spelling
	task automatic send_keyword(input int idx, input int keep_off);
		logic [47:0] spelling;
		spelling = kw_spelling(idx);
		for (int j = kw_size(idx) - 1; j >= keep_off; j--) begin
			send_byte(spelling[8*j +: 8], 1'b0);
		end
	endtask

	task automatic send_alnum(input int n);
		repeat (n) begin
			send_byte(pick_char(($urandom_range(2) == 0) ? CLASS_DIGIT : CLASS_LETTER), 1'b0);
		end
	endtask

	task automatic send_separator();
		int r;
		r = $urandom_range(9);
		if (r < 6) begin
			send_byte(pick_char(CLASS_BLANK), 1'b0);
		end else if (r < 8) begin
			send_byte(pick_char(CLASS_OP), 1'b0);
		end else if (r < 9) begin
			send_byte(pick_char(CLASS_DELIM), 1'b0);
		end
	endtask

	task automatic send_fragment();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1: begin
				send_keyword($urandom_range(KW_IDX_COUNT - 1), 0);
				send_separator();
			end
			2, 3: begin
				case ($urandom_range(3))
					0: begin
						send_keyword($urandom_range(KW_IDX_COUNT - 1), 0);
						send_alnum($urandom_range(1, 3));
					end
					1: send_keyword($urandom_range(KW_IDX_COUNT - 1), 1);
					default: begin
						send_byte(pick_char(CLASS_LETTER), 1'b0);
						send_alnum($urandom_range(0, 7));
					end
				endcase
				send_separator();
			end
			4: begin
				repeat ($urandom_range(1, 6)) begin
					send_byte(pick_char(CLASS_DIGIT), 1'b0);
				end
				send_separator();
			end
			5: send_byte(pick_char(CLASS_OP), 1'b0);
			6: send_byte(pick_char(CLASS_DELIM), 1'b0);
			7: send_byte(pick_char(CLASS_BLANK), 1'b0);
			8: send_byte(pick_char(CLASS_UNKNOWN), 1'b0);
			default: send_byte(8'($urandom), 1'b1);
		endcase
	endtask

	task automatic send_random(input int count);
		int first_item;
		first_item = items_sent;
		while (items_sent - first_item < count) begin
			if ($urandom_range(99) < 80) begin
				send_fragment();
			end else begin
				send_byte(8'($urandom), $urandom_range(9) == 0);
			end
		end
	endtask

	task automatic wait_drain();
		byte_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_tokens.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		sb = new();
		arst_n = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.ch = 8'h00;
		byte_bus.end_of_input = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_request = 1'b0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("int,if(a9)=42+*-; ", 18);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte("7", 1'b0);
		send_byte(8'($urandom), 1'b1);
		send_byte(8'($urandom), 1'b1);

		send_text("return", 6);
		repeat (LONG_RUN) send_byte("x", 1'b0);
		send_byte(CH_SPACE, 1'b0);

		hold_request = 1'b1;
		send_random(PRESSURE_ITEMS);
		wait_drain();

		send_random(PHASE_ITEMS);
		tx_idle_pct = 77;
		rx_stall_pct = 0;
		send_random(PHASE_ITEMS);
		wait_drain();
		tx_idle_pct = 0;
		rx_stall_pct = 77;
		send_random(PHASE_ITEMS);
		tx_idle_pct = 20;
		rx_stall_pct = 20;
		send_random(PHASE_ITEMS);

		wait_drain();
		repeat (8) @(posedge clk);
		sb.check_drained();

		$display("Scanned %0d bytes and end markers over four idling phases, %0d tokens checked.",
			sb.items_taken, sb.tokens_checked);
		$display("Included every token kind and keyword, high bytes, a long identifier, %s",
			"a long output stall.");
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cts_pkg.sv
rtl/core/cts_stream_if.sv
rtl/core/cts_front.sv
rtl/core/cts_queue.sv
rtl/core/cts_back.sv
rtl/core/c_subset_token_scanner_core.sv
rtl/core/cts_checker.sv
tb/sv/tb.sv
